// File: src/sactl_pkg.sv
// Shared types, constants and helper functions of the set-associative tag store.
`default_nettype none
package sactl_pkg;
   localparam int ADDR_BITS = 32;
   localparam int WAYS = 4;
   localparam int SET_COUNT = 64;
   localparam int LINE_BYTES = 64;
   localparam int TIME_BITS = 32;

   localparam int OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
   localparam int SET_BITS = $clog2(SET_COUNT + 1) - 1;
   localparam int SET_W = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_BITS = ADDR_BITS - OFF_BITS - SET_BITS;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SETS_USED = 1 << SET_BITS;
   localparam int CNT_W = 32;
   localparam int QDEPTH = 2;

   localparam logic [1:0] REQ_READ = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_PREFETCH = 2'd2;
   localparam logic [1:0] REQ_NONE = 2'd3;

   typedef logic [TAG_BITS-1:0] tag_type;
   typedef logic [TIME_BITS-1:0] stamp_type;
   typedef logic [SET_W-1:0] set_type;

   typedef struct packed {
      logic [1:0] kind;
      set_type set_idx;
      tag_type tag;
      stamp_type stamp;
   } job_type;

   typedef struct packed {
      logic valid;
      logic dirty;
      tag_type tag;
      stamp_type last_use;
   } line_type;

   function automatic set_type addr_set(input logic [ADDR_BITS-1:0] a);
      logic [ADDR_BITS-1:0] s;
      s = a >> OFF_BITS;
      if (SET_BITS == 0) return '0;
      return s[SET_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction
endpackage
`default_nettype wire

// File: src/set_assoc_cache_tag_lru.sv
// Top level of the set-associative write-back cache tag store with LRU replacement.
// Usage:
// The request channel takes a beat (req_type, req_addr, req_access_time) at a clock
// edge where start is high and busy is low. Requests enter a two-entry queue in
// the front end, so busy only rises when that queue is full.
// The back end reads all ways of the set in one step, then resolves hit or LRU
// victim and writes the set back in the next; it takes no new request until that
// write-back is done, so the sustained rate is set by the set read-modify-write.
// A request passes the queue, then the set read registers, then the result registers.
// Each result beat is on the rsp_ ports for one cycle, flagged by rsp_valid; the
// receiver cannot stall it and must take it that cycle.
// Statistics counters on rsp_ are 32 bits, saturate, and show values after the beat.
// Synchronous reset clears the queue, all line valid bits and all counters at once;
// the block takes requests in the first cycle after reset.
`default_nettype none
module set_assoc_cache_tag_lru
   import sactl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [1:0] req_type,
   input  wire logic [31:0] req_addr,
   input  wire logic [31:0] req_access_time,
   output logic rsp_valid,
   output logic rsp_hit,
   output logic rsp_evicted_dirty,
   output logic [31:0] rsp_evicted_line_addr,
   output logic [31:0] rsp_access_count,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_miss_count,
   output logic [31:0] rsp_writeback_count,
   output logic [31:0] rsp_prefetch_install_count,
   output logic [31:0] rsp_prefetch_redundant_count
);
   logic job_valid, job_take;
   job_type job;

   sactl_front u_front (
      .clock(clock), .reset(reset), .start(start),
      .req_type(req_type), .req_addr(req_addr), .req_access_time(req_access_time),
      .busy(busy), .job_valid(job_valid), .job(job), .job_take(job_take)
   );

   sactl_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job),
      .job_take(job_take), .done(rsp_valid),
      .rsp_hit(rsp_hit), .rsp_evicted_dirty(rsp_evicted_dirty),
      .rsp_evicted_line_addr(rsp_evicted_line_addr),
      .rsp_access_count(rsp_access_count), .rsp_hit_count(rsp_hit_count),
      .rsp_miss_count(rsp_miss_count), .rsp_writeback_count(rsp_writeback_count),
      .rsp_prefetch_install_count(rsp_prefetch_install_count),
      .rsp_prefetch_redundant_count(rsp_prefetch_redundant_count)
   );
endmodule
`default_nettype wire

// File: src/sactl_front.sv
// Front end: splits each request beat into set and tag and queues it for the back end.
`default_nettype none
module sactl_front
   import sactl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [1:0] req_type,
   input  wire logic [31:0] req_addr,
   input  wire logic [31:0] req_access_time,
   output logic busy,
   output logic job_valid,
   output job_type job,
   input  wire logic job_take
);
   localparam int PTR_W = $clog2(QDEPTH);

   job_type q_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0] cnt_ff, cnt_in;
   logic push;
   logic [ADDR_BITS-1:0] a;

   assign busy = (cnt_ff == QDEPTH[PTR_W:0]);
   assign push = start && !busy;
   assign job_valid = (cnt_ff != '0);
   assign job = q_ff[rd_ff];
   assign a = ADDR_BITS'(req_addr);

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = job_take ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, job_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff].kind <= req_type;
         q_ff[wr_ff].set_idx <= addr_set(a);
         q_ff[wr_ff].tag <= tag_type'(a >> (OFF_BITS + SET_BITS));
         q_ff[wr_ff].stamp <= stamp_type'(req_access_time);
      end
   end

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid) else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QDEPTH[PTR_W:0]) else $error("queue overflow");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !job_take |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count lost a push");
endmodule
`default_nettype wire

// File: src/sactl_back.sv
// Back end: reads a set, resolves hit and LRU victim, writes the set back and counts.
`default_nettype none
module sactl_back
   import sactl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic job_valid,
   input  job_type job,
   output logic job_take,
   output logic done,
   output logic rsp_hit,
   output logic rsp_evicted_dirty,
   output logic [31:0] rsp_evicted_line_addr,
   output logic [31:0] rsp_access_count,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_miss_count,
   output logic [31:0] rsp_writeback_count,
   output logic [31:0] rsp_prefetch_install_count,
   output logic [31:0] rsp_prefetch_redundant_count
);
   localparam int ENTRIES = SETS_USED * WAYS;

   line_type mem_ff [SETS_USED][WAYS];
   logic [ENTRIES-1:0] vld_ff, vld_in;
   line_type rd_ff [WAYS];
   job_type cur_ff;
   logic phase_ff, phase_in;
   logic done_ff;
   logic hit_ff, evd_ff;
   logic [31:0] eva_ff;
   logic [CNT_W-1:0] acc_ff, hc_ff, mc_ff, wb_ff, pi_ff, pr_ff;

   line_type ln [WAYS];
   logic found;
   logic [WAY_W-1:0] fway, vway, way;
   logic any_inv;
   stamp_type best;
   logic ev_dirty;
   logic [ADDR_BITS-1:0] ev_full;
   logic act, pf;
   line_type newl;

   assign job_take = job_valid && !phase_ff;
   assign act = phase_ff && (cur_ff.kind != REQ_NONE);
   assign pf = (cur_ff.kind == REQ_PREFETCH);

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         ln[w] = rd_ff[w];
         ln[w].valid = vld_ff[int'(cur_ff.set_idx) * WAYS + w];
      end
      found = 1'b0;
      fway = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (ln[w].valid && ln[w].tag == cur_ff.tag) begin
            found = 1'b1;
            fway = WAY_W'(w);
         end
      end
      any_inv = 1'b0;
      vway = '0;
      best = ln[0].last_use;
      for (int w = 1; w < WAYS; w++) begin
         if (ln[w].last_use < best) begin
            best = ln[w].last_use;
            vway = WAY_W'(w);
         end
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!ln[w].valid) begin
            any_inv = 1'b1;
            vway = WAY_W'(w);
         end
      end
      way = found ? fway : vway;
      ev_dirty = act && !found && !any_inv && ln[vway].dirty;
      ev_full = (ADDR_BITS'(ln[vway].tag) << (OFF_BITS + SET_BITS))
         | (ADDR_BITS'(cur_ff.set_idx) << OFF_BITS);
      if (SET_BITS == 0) ev_full = ADDR_BITS'(ln[vway].tag) << OFF_BITS;
      newl.valid = 1'b1;
      newl.tag = cur_ff.tag;
      newl.last_use = cur_ff.stamp;
      newl.dirty = found ? (ln[fway].dirty || cur_ff.kind == REQ_WRITE)
         : (cur_ff.kind == REQ_WRITE);
      vld_in = vld_ff;
      if (act) vld_in[int'(cur_ff.set_idx) * WAYS + int'(way)] = 1'b1;
      phase_in = phase_ff ? 1'b0 : job_valid;
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         cur_ff <= job;
         for (int w = 0; w < WAYS; w++) rd_ff[w] <= mem_ff[job.set_idx][w];
      end
      if (act) mem_ff[cur_ff.set_idx][way] <= newl;
   end

   always_ff @(posedge clock) begin
      hit_ff <= act && found;
      evd_ff <= ev_dirty;
      eva_ff <= ev_dirty ? 32'(ev_full) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         phase_ff <= 1'b0;
         done_ff <= 1'b0;
         acc_ff <= '0;
         hc_ff <= '0;
         mc_ff <= '0;
         wb_ff <= '0;
         pi_ff <= '0;
         pr_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         phase_ff <= phase_in;
         done_ff <= phase_ff;
         if (act && !pf) acc_ff <= sat_inc(acc_ff);
         if (act && !pf && found) hc_ff <= sat_inc(hc_ff);
         if (act && !pf && !found) mc_ff <= sat_inc(mc_ff);
         if (ev_dirty) wb_ff <= sat_inc(wb_ff);
         if (act && pf && !found) pi_ff <= sat_inc(pi_ff);
         if (act && pf && found) pr_ff <= sat_inc(pr_ff);
      end
   end

   assign done = done_ff;
   assign rsp_hit = hit_ff;
   assign rsp_evicted_dirty = evd_ff;
   assign rsp_evicted_line_addr = eva_ff;
   assign rsp_access_count = acc_ff;
   assign rsp_hit_count = hc_ff;
   assign rsp_miss_count = mc_ff;
   assign rsp_writeback_count = wb_ff;
   assign rsp_prefetch_install_count = pi_ff;
   assign rsp_prefetch_redundant_count = pr_ff;

   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      phase_ff |=> done_ff) else $error("result beat missing");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !job_take) else $error("job taken mid-update");
   a_evict_clean_hit: assert property (@(posedge clock) disable iff (reset)
      done_ff && rsp_hit |-> !rsp_evicted_dirty) else $error("eviction on hit");
   a_miss_count_moves: assert property (@(posedge clock) disable iff (reset)
      act && !pf && !found && !(&mc_ff) |=> mc_ff == $past(mc_ff) + 1'b1)
      else $error("miss not counted");
endmodule
`default_nettype wire

// File: dv/set_assoc_cache_tag_lru_test.sv
// Self-checking testbench of the set-associative cache tag store with LRU replacement.
module set_assoc_cache_tag_lru_test;
   import sactl_pkg::*;

   typedef struct {
      logic        hit;
      logic        ev_dirty;
      logic [31:0] ev_addr;
      logic [31:0] cnt[6];
   } outcome_type;

   localparam int CNT_ACC = 0;
   localparam int CNT_HIT = 1;
   localparam int CNT_MISS = 2;
   localparam int CNT_WB = 3;
   localparam int CNT_PF_INST = 4;
   localparam int CNT_PF_RED = 5;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic [1:0] req_type = REQ_READ;
   logic [31:0] req_addr = 0;
   logic [31:0] req_access_time = 0;
   logic busy, rsp_valid, rsp_hit, rsp_evicted_dirty;
   logic [31:0] rsp_evicted_line_addr, rsp_access_count, rsp_hit_count, rsp_miss_count;
   logic [31:0] rsp_writeback_count, rsp_prefetch_install_count;
   logic [31:0] rsp_prefetch_redundant_count;

   logic        way_valid[SET_COUNT][WAYS];
   logic        way_dirty[SET_COUNT][WAYS];
   logic [31:0] way_tag[SET_COUNT][WAYS];
   logic [31:0] way_last_use[SET_COUNT][WAYS];
   logic [31:0] stats[6];
   outcome_type pending_outcomes[$];
   int          mismatches = 0;
   logic [31:0] clock_stamp = 0;

   set_assoc_cache_tag_lru DUT (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void bump_stat(int which);
      if (stats[which] != 32'hFFFF_FFFF) stats[which]++;
   endfunction

   function automatic outcome_type predict_lookup(logic [1:0] kind, logic [31:0] a,
                                                  logic [31:0] now);
      outcome_type o;
      int s, found, victim;
      logic [31:0] tag, best;
      s = (a >> OFF_BITS) % SET_COUNT;
      tag = a >> (OFF_BITS + SET_BITS);
      found = -1;
      victim = -1;
      best = 0;
      o.hit = 0;
      o.ev_dirty = 0;
      o.ev_addr = 0;
      if (kind != REQ_NONE) begin
         for (int w = 0; w < WAYS; w++)
            if (found < 0 && way_valid[s][w] && way_tag[s][w] == tag) found = w;
         if (kind != REQ_PREFETCH) bump_stat(CNT_ACC);
         if (found >= 0) begin
            o.hit = 1;
            way_last_use[s][found] = now;
            if (kind == REQ_WRITE) way_dirty[s][found] = 1;
            bump_stat(kind == REQ_PREFETCH ? CNT_PF_RED : CNT_HIT);
         end else begin
            for (int w = 0; w < WAYS; w++) begin
               if (!way_valid[s][w]) begin
                  victim = w;
                  break;
               end
               if (victim < 0 || way_last_use[s][w] < best) begin
                  best = way_last_use[s][w];
                  victim = w;
               end
            end
            if (way_valid[s][victim] && way_dirty[s][victim]) begin
               o.ev_dirty = 1;
               o.ev_addr = (way_tag[s][victim] << (OFF_BITS + SET_BITS)) |
                           (32'(s) << OFF_BITS);
               bump_stat(CNT_WB);
            end
            way_valid[s][victim] = 1;
            way_tag[s][victim] = tag;
            way_dirty[s][victim] = (kind == REQ_WRITE);
            way_last_use[s][victim] = now;
            bump_stat(kind == REQ_PREFETCH ? CNT_PF_INST : CNT_MISS);
         end
      end
      o.cnt = stats;
      return o;
   endfunction

   task automatic send_request(logic [1:0] kind, logic [31:0] a, logic [31:0] now);
      start <= 1;
      req_type <= kind;
      req_addr <= a;
      req_access_time <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_outcomes.push_back(predict_lookup(kind, a, now));
      if ($urandom_range(3) == 0) begin
         start <= 0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] line_addr(int s, logic [31:0] tag);
      return (tag << (OFF_BITS + SET_BITS)) | (32'(s) << OFF_BITS) |
             32'($urandom_range(LINE_BYTES - 1));
   endfunction

   task automatic test_directed();
      send_request(REQ_READ, 32'h0, 32'h0);
      send_request(REQ_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(REQ_PREFETCH, 32'hFFFF_FFC0, 32'h5);
      send_request(REQ_PREFETCH, 32'h1234_5000, 32'h6);
      send_request(REQ_NONE, 32'h1234_5000, 32'h7);
      for (int t = 0; t < 6; t++)
         send_request(REQ_WRITE, line_addr(3, t), 32'(10 + t));
      send_request(REQ_READ, line_addr(3, 5), 32'd10);
      for (int t = 0; t < 5; t++)
         send_request(REQ_WRITE, line_addr(9, t), 32'd50);
      send_request(REQ_PREFETCH, line_addr(9, 7), 32'd0);
      send_request(REQ_READ, line_addr(9, 8), 32'hFFFF_FFFF);
   endtask

   task automatic test_random();
      logic [1:0] kind;
      logic [31:0] a;
      for (int n = 0; n < 800; n++) begin
         kind = 2'($urandom_range(3));
         if (kind == REQ_NONE && $urandom_range(3) != 0) kind = REQ_READ;
         if ($urandom_range(9) == 0) a = $urandom;
         else a = line_addr($urandom_range(3), $urandom_range(7));
         clock_stamp = ($urandom_range(15) == 0) ? $urandom
                                                 : clock_stamp + $urandom_range(3);
         send_request(kind, a, clock_stamp);
         if ($urandom_range(40) == 0) begin
            start <= 0;
            repeat ($urandom_range(20, 5)) @(posedge clock);
         end
      end
      start <= 0;
   endtask

   always @(posedge clock) begin
      outcome_type e;
      logic [31:0] got[6];
      if (!reset && rsp_valid) begin
         got = '{rsp_access_count, rsp_hit_count, rsp_miss_count, rsp_writeback_count,
                 rsp_prefetch_install_count, rsp_prefetch_redundant_count};
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: got %0b %0b %h %p", rsp_hit,
                        rsp_evicted_dirty, rsp_evicted_line_addr, got);
         end else begin
            e = pending_outcomes.pop_front();
            if (e.hit !== rsp_hit || e.ev_dirty !== rsp_evicted_dirty ||
                e.ev_addr !== rsp_evicted_line_addr || e.cnt != got) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0b %0b %h %p, got %0b %0b %h %p",
                           e.hit, e.ev_dirty, e.ev_addr, e.cnt, rsp_hit,
                           rsp_evicted_dirty, rsp_evicted_line_addr, got);
            end
         end
      end
   end

   initial begin
      for (int s = 0; s < SET_COUNT; s++)
         for (int w = 0; w < WAYS; w++) begin
            way_valid[s][w] = 0;
            way_dirty[s][w] = 0;
            way_tag[s][w] = 0;
            way_last_use[s][w] = 0;
         end
      stats = '{default: 0};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
